FILE: src/mipt_pkg.sv
`default_nettype none
package mipt_pkg;

    localparam int HeaderStoreBytesDefault = 64;
    localparam logic [5:0] FwdHdrBytes = 6'd12;
    localparam logic [15:0] FwdHdrLen = 16'd12;
    localparam logic [3:0] FwdHdrWords = 4'd3;
    localparam logic [7:0] ProtoMinEnc = 8'd55;
    localparam logic [7:0] SBitByte = 8'h80;
    localparam logic [15:0] ChkInit = 16'hffff;
    localparam logic [3:0] IhlMinEncap = 4'd5;
    localparam logic [3:0] IhlMaxEncap = 4'd12;
    localparam logic [3:0] IhlMinDecap = 4'd8;

    localparam logic [1:0] CfgTunnelMode = 2'd0;
    localparam logic [1:0] CfgTunnelSrc = 2'd1;
    localparam logic [1:0] CfgTunnelDst = 2'd2;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_PASS,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        SEL_RAM,
        SEL_IHL,
        SEL_LEN_HI,
        SEL_LEN_LO,
        SEL_PROTO,
        SEL_SBIT,
        SEL_CHK_A_HI,
        SEL_CHK_A_LO,
        SEL_CHK_B_HI,
        SEL_CHK_B_LO,
        SEL_SRC,
        SEL_DST
    } sel_t;

    typedef struct packed {
        logic       in_fire;
        logic       acc_en;
        logic       emit_load;
        logic       burst_done;
        logic       pass;
        logic [5:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic hdr_done;
        logic out_free;
        logic idx_last;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: src/minimal_ip_tunnel_encap_decap.sv
// channel   direction  tdata / data                           tlast / tuser
// s_axis    in         [7:0] data_byte, [23:8] packet_length  tlast last_byte
// m_axis    out        [7:0] out_byte                         tlast out_last, tuser packet_error
// cfg       in         cfg_index, cfg_data[31:0]              always ready
//
// payload and dropped bytes: one transfer per cycle unless m_axis stalls, one output register
// header of n output bytes: input stalls after the completing byte while the n bytes are
// gathered over the registered header ram read port, once for the checksum pass and once
// for emission; emission also waits while m_axis stalls
// asynchronous active-low reset clears control state; no clearing pass on the header ram
`default_nettype none
module minimal_ip_tunnel_encap_decap
    import mipt_pkg::*;
#(
    parameter int HEADER_STORE_BYTES = HeaderStoreBytesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // data_byte, packet_length
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,   // packet_error
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mipt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mipt_dp #(
        .HEADER_STORE_BYTES(HEADER_STORE_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata[7:0]),
        .in_last  (s_axis_tlast),
        .in_len   (s_axis_tdata[23:8]),
        .cfg_valid(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata),
        .out_last (m_axis_tlast),
        .out_err  (m_axis_tuser)
    );

    a_no_input_during_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc_en || cmd.emit_load) |-> !s_axis_tready)
        else $error("input accepted during header burst");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
        else $error("malformed error result");

    a_stall_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && stat.hdr_done) |=> !s_axis_tready)
        else $error("input not stalled after header");

endmodule
`default_nettype wire

FILE: src/mipt_ram.sv
`default_nettype none
module mipt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: src/mipt_ctrl.sv
`default_nettype none
module mipt_ctrl
    import mipt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t     state_reg, state_next;
    logic [5:0] idx_reg, idx_next;
    logic       primed_reg, primed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RECV;
            idx_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            primed_reg <= primed_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        primed_next = primed_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.idx     = idx_reg;
        cmd.pass    = (state_reg == ST_PASS);
        unique case (state_reg)
            ST_RECV:
            begin
                in_ready    = stat.out_free;
                cmd.in_fire = in_valid && stat.out_free;
                if (cmd.in_fire && stat.hdr_done)
                begin
                    state_next  = ST_PASS;
                    idx_next    = '0;
                    primed_next = 1'b0;
                end
            end
            ST_PASS:
            begin
                if (!primed_reg)
                begin
                    primed_next = 1'b1;
                end
                else
                begin
                    cmd.acc_en  = 1'b1;
                    primed_next = 1'b0;
                    if (stat.idx_last)
                    begin
                        state_next = ST_EMIT;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!primed_reg)
                begin
                    primed_next = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    primed_next   = 1'b0;
                    if (stat.idx_last)
                    begin
                        cmd.burst_done = 1'b1;
                        state_next     = ST_RECV;
                        idx_next       = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/mipt_dp.sv
`default_nettype none
module mipt_dp
    import mipt_pkg::*;
#(
    parameter int HEADER_STORE_BYTES = HeaderStoreBytesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    input  wire logic [7:0]  in_data,
    input  wire logic        in_last,
    input  wire logic [15:0] in_len,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_data,
    output logic             out_last,
    output logic             out_err
);

    localparam int AW = $clog2(HEADER_STORE_BYTES);

    logic        mode_reg, mode_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] pos_reg, pos_next;
    logic [5:0]  hexp_reg, hexp_next;
    logic        drop_reg, drop_next;
    logic        lasthdr_reg, lasthdr_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] acca_reg, acca_next;
    logic [15:0] accb_reg, accb_next;
    logic [7:0]  hi_reg, hi_next;
    logic        oval_reg, oval_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;
    logic        oerr_reg, oerr_next;

    logic [3:0]  ihl;
    logic        bad;
    logic        pos_zero;
    logic [5:0]  hexp_eff;
    logic        in_hdr;
    logic [15:0] pos_inc;
    logic        store_en;
    logic        out_free;
    logic [7:0]  rdata;

    logic [5:0]  dlen;
    logic [5:0]  base;
    logic [5:0]  nlen;
    logic [5:0]  jdx;
    logic [3:0]  ihl_new;
    sel_t        sel;
    logic [5:0]  gaddr;
    logic [7:0]  gbyte;
    logic [15:0] chk_a;
    logic [15:0] chk_b;
    logic [31:0] src_sh;
    logic [31:0] dst_sh;
    logic [16:0] wsum;
    logic [15:0] wres;
    logic [15:0] acc_sel;

    mipt_ram #(
        .WIDTH(8),
        .DEPTH(HEADER_STORE_BYTES)
    ) u_ram (
        .clk  (clk),
        .we   (store_en),
        .waddr(pos_reg[AW-1:0]),
        .wdata(in_data),
        .raddr(gaddr[AW-1:0]),
        .rdata(rdata)
    );

    assign out_free = !oval_reg || out_ready;
    assign ihl      = in_data[3:0];
    assign bad      = mode_reg ? (ihl < IhlMinDecap)
                               : (ihl < IhlMinEncap || ihl > IhlMaxEncap);
    assign pos_zero = (pos_reg == 16'd0);
    assign hexp_eff = pos_zero ? {ihl, 2'b00} : hexp_reg;
    assign in_hdr   = (pos_reg < {10'd0, hexp_eff});
    assign pos_inc  = pos_reg + 16'd1;
    assign store_en = cmd.in_fire && !drop_reg && !(pos_zero && bad) && in_hdr;

    assign dlen    = hexp_reg - FwdHdrBytes;
    assign base    = mode_reg ? dlen : hexp_reg;
    assign nlen    = mode_reg ? dlen : hexp_reg + FwdHdrBytes;
    assign jdx     = cmd.idx - base;
    assign ihl_new = mode_reg ? hexp_reg[5:2] - FwdHdrWords : hexp_reg[5:2] + FwdHdrWords;

    assign stat.hdr_done = !drop_reg && !(pos_zero && bad) && in_hdr
                           && (pos_inc == {10'd0, hexp_eff});
    assign stat.out_free = out_free;
    assign stat.idx_last = (cmd.idx == nlen - 6'd1);

    // output byte source for header index
    always_comb
    begin
        sel   = SEL_RAM;
        gaddr = cmd.idx;
        if (!mode_reg && cmd.idx >= hexp_reg)
        begin
            // forwarding header
            priority if (jdx == 6'd0)
            begin
                gaddr = 6'd9;
            end
            else if (jdx == 6'd1)
            begin
                sel = SEL_SBIT;
            end
            else if (jdx == 6'd2)
            begin
                sel = SEL_CHK_B_HI;
            end
            else if (jdx == 6'd3)
            begin
                sel = SEL_CHK_B_LO;
            end
            else if (jdx < 6'd8)
            begin
                gaddr = jdx + 6'd12;
            end
            else
            begin
                gaddr = jdx + 6'd4;
            end
        end
        else
        begin
            priority if (cmd.idx == 6'd0)
            begin
                sel = SEL_IHL;
            end
            else if (cmd.idx == 6'd2)
            begin
                sel = SEL_LEN_HI;
            end
            else if (cmd.idx == 6'd3)
            begin
                sel = SEL_LEN_LO;
            end
            else if (cmd.idx == 6'd9)
            begin
                if (mode_reg)
                begin
                    gaddr = dlen;
                end
                else
                begin
                    sel = SEL_PROTO;
                end
            end
            else if (cmd.idx == 6'd10)
            begin
                sel = SEL_CHK_A_HI;
            end
            else if (cmd.idx == 6'd11)
            begin
                sel = SEL_CHK_A_LO;
            end
            else if (cmd.idx >= 6'd12 && cmd.idx < 6'd16)
            begin
                if (mode_reg)
                begin
                    gaddr = dlen + cmd.idx - 6'd4;
                end
                else
                begin
                    sel = SEL_SRC;
                end
            end
            else if (cmd.idx >= 6'd16 && cmd.idx < 6'd20)
            begin
                if (mode_reg)
                begin
                    gaddr = dlen + cmd.idx - 6'd12;
                end
                else
                begin
                    sel = SEL_DST;
                end
            end
        end
    end

    assign chk_a  = cmd.pass ? 16'd0 : ~acca_reg;
    assign chk_b  = cmd.pass ? 16'd0 : ~accb_reg;
    assign src_sh = src_reg << {cmd.idx[1:0], 3'b000};
    assign dst_sh = dst_reg << {cmd.idx[1:0], 3'b000};

    always_comb
    begin
        unique case (sel)
            SEL_RAM:      gbyte = rdata;
            SEL_IHL:      gbyte = {rdata[7:4], ihl_new};
            SEL_LEN_HI:   gbyte = len_reg[15:8];
            SEL_LEN_LO:   gbyte = len_reg[7:0];
            SEL_PROTO:    gbyte = ProtoMinEnc;
            SEL_SBIT:     gbyte = SBitByte;
            SEL_CHK_A_HI: gbyte = chk_a[15:8];
            SEL_CHK_A_LO: gbyte = chk_a[7:0];
            SEL_CHK_B_HI: gbyte = chk_b[15:8];
            SEL_CHK_B_LO: gbyte = chk_b[7:0];
            SEL_SRC:      gbyte = src_sh[31:24];
            SEL_DST:      gbyte = dst_sh[31:24];
            default:      gbyte = rdata;
        endcase
    end

    // ones' complement word add with end-around carry
    assign acc_sel = (cmd.idx < base) ? acca_reg : accb_reg;
    assign wsum    = {1'b0, acc_sel} + {1'b0, hi_reg, gbyte};
    assign wres    = wsum[16] ? wsum[15:0] + 16'd1 : wsum[15:0];

    always_comb
    begin
        mode_next    = mode_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        pos_next     = pos_reg;
        hexp_next    = hexp_reg;
        drop_next    = drop_reg;
        lasthdr_next = lasthdr_reg;
        len_next     = len_reg;
        acca_next    = acca_reg;
        accb_next    = accb_reg;
        hi_next      = hi_reg;
        oval_next    = oval_reg;
        obyte_next   = obyte_reg;
        olast_next   = olast_reg;
        oerr_next    = oerr_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CfgTunnelMode: mode_next = cfg_data[0];
                CfgTunnelSrc:  src_next = cfg_data;
                CfgTunnelDst:  dst_next = cfg_data;
                default:       mode_next = mode_reg;
            endcase
        end

        if (out_ready)
        begin
            oval_next = 1'b0;
        end

        if (cmd.in_fire)
        begin
            if (drop_reg)
            begin
                if (in_last)
                begin
                    drop_next = 1'b0;
                    pos_next  = '0;
                    hexp_next = '0;
                end
            end
            else if (pos_zero && bad)
            begin
                oval_next  = 1'b1;
                obyte_next = 8'd0;
                olast_next = 1'b1;
                oerr_next  = 1'b1;
                pos_next   = '0;
                hexp_next  = '0;
                drop_next  = !in_last;
            end
            else if (in_hdr)
            begin
                pos_next  = pos_inc;
                hexp_next = hexp_eff;
                if (stat.hdr_done)
                begin
                    lasthdr_next = in_last;
                    len_next     = mode_reg ? in_len - FwdHdrLen : in_len + FwdHdrLen;
                    acca_next    = ChkInit;
                    accb_next    = ChkInit;
                end
                else if (in_last)
                begin
                    oval_next  = 1'b1;
                    obyte_next = 8'd0;
                    olast_next = 1'b1;
                    oerr_next  = 1'b1;
                    pos_next   = '0;
                    hexp_next  = '0;
                end
            end
            else
            begin
                oval_next  = 1'b1;
                obyte_next = in_data;
                olast_next = in_last;
                oerr_next  = 1'b0;
                if (in_last)
                begin
                    pos_next  = '0;
                    hexp_next = '0;
                end
                else if (pos_reg != 16'hffff)
                begin
                    pos_next = pos_inc;
                end
            end
        end

        if (cmd.acc_en)
        begin
            if (!cmd.idx[0])
            begin
                hi_next = gbyte;
            end
            else if (cmd.idx < base)
            begin
                acca_next = wres;
            end
            else
            begin
                accb_next = wres;
            end
        end

        if (cmd.emit_load)
        begin
            oval_next  = 1'b1;
            obyte_next = gbyte;
            olast_next = lasthdr_reg && stat.idx_last;
            oerr_next  = 1'b0;
        end

        if (cmd.burst_done && lasthdr_reg)
        begin
            pos_next  = '0;
            hexp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            src_reg     <= '0;
            dst_reg     <= '0;
            pos_reg     <= '0;
            hexp_reg    <= '0;
            drop_reg    <= 1'b0;
            lasthdr_reg <= 1'b0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            pos_reg     <= pos_next;
            hexp_reg    <= hexp_next;
            drop_reg    <= drop_next;
            lasthdr_reg <= lasthdr_next;
            oval_reg    <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        acca_reg  <= acca_next;
        accb_reg  <= accb_next;
        hi_reg    <= hi_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign out_valid = oval_reg;
    assign out_data  = obyte_reg;
    assign out_last  = olast_reg;
    assign out_err   = oerr_reg;

endmodule
`default_nettype wire

FILE: bench/minimal_ip_tunnel_encap_decap_chk.sv
module minimal_ip_tunnel_encap_decap_chk
    import mipt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic        m_axis_tlast,
    input  wire logic        m_axis_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } out_beat_t;

    out_beat_t   beat_q[$];
    logic [7:0]  hdr[64];
    logic [15:0] pos;
    logic [5:0]  hdr_len;
    logic        dropping;
    logic        mode;
    logic [31:0] outer_src;
    logic [31:0] outer_dst;

    assign pending = beat_q.size();

    function automatic logic [15:0] csum(input logic [7:0] b[60], input int first, input int n);
        logic [16:0] acc;
        acc = 17'h0ffff;
        for (int i = 0; i + 1 < n; i += 2)
        begin
            acc = acc + {b[first + i], b[first + i + 1]};
            if (acc > 17'h0ffff)
                acc = acc - 17'h0ffff;
        end
        return ~acc[15:0];
    endfunction

    task automatic push(input logic [7:0] d, input logic l, input logic e);
        out_beat_t b;
        b.data = d;
        b.last = l;
        b.err = e;
        beat_q.push_back(b);
    endtask

    task automatic rewrite_header(input logic [15:0] plen, input logic last);
        logic [7:0]  buf_b[60];
        logic [7:0]  fwd[60];
        logic [15:0] c;
        int          h;
        int          n;
        h = hdr_len;
        for (int i = 0; i < 60; i++)
        begin
            buf_b[i] = 8'h00;
            fwd[i] = 8'h00;
        end
        if (!mode)
        begin
            for (int i = 0; i < h; i++)
                buf_b[i] = hdr[i];
            buf_b[0] = {hdr[0][7:4], 4'((h + 12) / 4)};
            {buf_b[2], buf_b[3]} = plen + FwdHdrLen;
            buf_b[9] = ProtoMinEnc;
            buf_b[10] = 8'h00;
            buf_b[11] = 8'h00;
            {buf_b[12], buf_b[13], buf_b[14], buf_b[15]} = outer_src;
            {buf_b[16], buf_b[17], buf_b[18], buf_b[19]} = outer_dst;
            fwd[0] = hdr[9];
            fwd[1] = SBitByte;
            for (int i = 0; i < 4; i++)
            begin
                fwd[4 + i] = hdr[16 + i];
                fwd[8 + i] = hdr[12 + i];
            end
            c = csum(fwd, 0, 12);
            fwd[2] = c[15:8];
            fwd[3] = c[7:0];
            for (int i = 0; i < 12; i++)
                buf_b[h + i] = fwd[i];
            n = h + 12;
        end
        else
        begin
            n = h - 12;
            for (int i = 0; i < n; i++)
                buf_b[i] = hdr[i];
            buf_b[0] = {hdr[0][7:4], 4'(n / 4)};
            {buf_b[2], buf_b[3]} = plen - FwdHdrLen;
            buf_b[9] = hdr[n];
            buf_b[10] = 8'h00;
            buf_b[11] = 8'h00;
            for (int i = 0; i < 4; i++)
            begin
                buf_b[12 + i] = hdr[n + 8 + i];
                buf_b[16 + i] = hdr[n + 4 + i];
            end
        end
        c = csum(buf_b, 0, n);
        buf_b[10] = c[15:8];
        buf_b[11] = c[7:0];
        for (int i = 0; i < n; i++)
            push(buf_b[i], last && (i == n - 1), 1'b0);
    endtask

    task automatic predict(input logic [7:0] b, input logic last, input logic [15:0] plen);
        logic [3:0] ihl;
        logic       bad;
        ihl = b[3:0];
        if (dropping)
        begin
            if (last)
            begin
                dropping = 1'b0;
                pos = '0;
                hdr_len = '0;
            end
            return;
        end
        if (pos == 0)
        begin
            bad = !mode ? (ihl < IhlMinEncap || ihl > IhlMaxEncap) : (ihl < IhlMinDecap);
            if (bad)
            begin
                push(8'h00, 1'b1, 1'b1);
                pos = '0;
                hdr_len = '0;
                dropping = !last;
                return;
            end
            hdr_len = {ihl, 2'b00};
        end
        if (pos < hdr_len)
        begin
            hdr[pos[5:0]] = b;
            pos = pos + 1;
            if (pos == hdr_len)
            begin
                rewrite_header(plen, last);
                if (last)
                begin
                    pos = '0;
                    hdr_len = '0;
                end
            end
            else if (last)
            begin
                push(8'h00, 1'b1, 1'b1);
                pos = '0;
                hdr_len = '0;
            end
            return;
        end
        push(b, last, 1'b0);
        if (last)
        begin
            pos = '0;
            hdr_len = '0;
        end
        else if (pos != 16'hffff)
            pos = pos + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            pos = '0;
            hdr_len = '0;
            dropping = 1'b0;
            mode = 1'b0;
            outer_src = '0;
            outer_dst = '0;
            fail_count = 0;
            beat_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CfgTunnelMode: mode = cfg_data[0];
                    CfgTunnelSrc:  outer_src = cfg_data;
                    CfgTunnelDst:  outer_dst = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict(s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[23:8]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (beat_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transfer: data %h last %b err %b",
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
                else
                begin
                    want = beat_q.pop_front();
                    if (want.data !== m_axis_tdata || want.last !== m_axis_tlast
                        || want.err !== m_axis_tuser)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                                     want.data, want.last, want.err,
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end
            end
        end
    end
endmodule

FILE: bench/minimal_ip_tunnel_encap_decap_tb.sv
module minimal_ip_tunnel_encap_decap_tb
    import mipt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    logic        cur_mode = 1'b0;

    always #1 clk = ~clk;

    minimal_ip_tunnel_encap_decap dut (.*);

    minimal_ip_tunnel_encap_decap_chk chk (.*);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("minimal_ip_tunnel_encap_decap regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CfgTunnelMode)
            cur_mode = val[0];
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input logic [15:0] plen);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {plen, b};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // ihl_byte carries version and ihl; cut ends the packet early at that many bytes
    task automatic send_packet(input logic [7:0] ihl_byte, input int payload, input int cut);
        int          hlen;
        int          total;
        logic [15:0] plen;
        logic [7:0]  b;
        hlen = ihl_byte[3:0] * 4;
        if (hlen == 0)
            hlen = 1;
        total = hlen + payload;
        if (cut > 0 && cut < total)
            total = cut;
        plen = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(hlen + payload);
        for (int i = 0; i < total; i++)
        begin
            b = (i == 0) ? ihl_byte : 8'($urandom);
            send_byte(b, i == total - 1, plen);
        end
    endtask

    task automatic drain();
        stop_sending();
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic random_phase(input int n_items);
        logic [3:0] ihl;
        int         r;
        int         start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            r = $urandom_range(99);
            if (cur_mode)
                ihl = 4'($urandom_range(8, 15));
            else
                ihl = 4'($urandom_range(5, 12));
            if (r < 10)
                ihl = 4'($urandom);
            if (r >= 10 && r < 18)
                send_packet({4'($urandom), ihl}, 0, $urandom_range(1, ihl * 4));
            else
                send_packet({4'($urandom), ihl}, $urandom_range(0, 12), 0);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // encap directed
        write_reg(CfgTunnelSrc, 32'hffff_ffff);
        write_reg(CfgTunnelDst, 32'h0000_0000);
        write_reg(CfgTunnelMode, 32'd0);
        send_packet(8'h45, 2, 0);
        send_packet(8'hfc, 0, 0);
        send_packet(8'h44, 3, 0);
        send_packet(8'h4d, 3, 0);
        send_packet(8'h46, 0, 10);
        send_byte(8'h45, 1'b1, 16'hffff);
        drain();

        write_reg(CfgTunnelMode, 32'd1);
        send_packet(8'h48, 0, 0);
        send_packet(8'h4f, 1, 0);
        send_packet(8'h47, 2, 0);
        send_packet(8'h49, 0, 5);
        drain();

        write_reg(CfgTunnelSrc, 32'($urandom));
        write_reg(CfgTunnelDst, 32'($urandom));
        write_reg(CfgTunnelMode, 32'd0);
        send_idle_pct = 24;
        recv_idle_pct = 88;
        random_phase(70);
        drain();

        write_reg(CfgTunnelMode, 32'd1);
        send_idle_pct = 88;
        recv_idle_pct = 24;
        random_phase(70);
        drain();

        write_reg(CfgTunnelSrc, 32'($urandom));
        write_reg(CfgTunnelMode, 32'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 400;
        random_phase(70);
        drain();

        if (fail_count == 0)
            $display("minimal_ip_tunnel_encap_decap regression: pass");
        else
            $display("minimal_ip_tunnel_encap_decap regression: fail");
        $finish;
    end
endmodule

FILE: sim.f
src/mipt_pkg.sv
src/mipt_ram.sv
src/mipt_ctrl.sv
src/mipt_dp.sv
src/minimal_ip_tunnel_encap_decap.sv
bench/minimal_ip_tunnel_encap_decap_chk.sv
bench/minimal_ip_tunnel_encap_decap_tb.sv
